FILE: rtl/c3s_pkg.sv
`timescale 1ns / 1ps

package c3s_pkg;

  localparam int DATA_W       = 32;
  localparam int TILE_SIDE_W  = 9;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int MAX_TILE_DEF = 256;
  localparam int TILE_SIDE_RST = 256;
  localparam int NUM_COEFF    = 9;

  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TILE_SIDE    = 3'd0,
    REG_COEFF_PAIR_A = 3'd1,
    REG_COEFF_PAIR_B = 3'd2,
    REG_COEFF_PAIR_C = 3'd3,
    REG_COEFF_PAIR_D = 3'd4,
    REG_COEFF_LAST   = 3'd5
  } cfg_reg_t;

endpackage

FILE: rtl/c3s_cell.sv
`timescale 1ns / 1ps

// One window tap: takes the pixel from its right-hand neighbor on a shift
// and registers its weighted product.
module c3s_cell (
  input  logic                clk,
  input  logic                shift,
  input  c3s_pkg::word_t      tap_in,
  input  c3s_pkg::word_t      coeff,
  output c3s_pkg::word_t      tap_out,
  output c3s_pkg::word_t      prod_out
);

  c3s_pkg::word_t tap_r;
  c3s_pkg::word_t prod_r;
  c3s_pkg::word_t prod_nxt;

  assign prod_nxt = tap_in * coeff;

  always_ff @(posedge clk) begin
    if (shift) begin
      tap_r  <= tap_in;
      prod_r <= prod_nxt;
    end
  end

  assign tap_out  = tap_r;
  assign prod_out = prod_r;

endmodule

FILE: rtl/c3s_line_mem.sv
`timescale 1ns / 1ps

// Two padded rows side by side in one word: older row low, newer row high.
module c3s_line_mem #(
  parameter int DEPTH = c3s_pkg::MAX_TILE_DEF + 2
) (
  input  logic                            clk,
  input  logic                            rd_en,
  input  logic [$clog2(DEPTH)-1:0]        rd_addr,
  output logic [2*c3s_pkg::DATA_W-1:0]    rd_data,
  input  logic                            wr_en,
  input  logic [$clog2(DEPTH)-1:0]        wr_addr,
  input  logic [2*c3s_pkg::DATA_W-1:0]    wr_data
);

  logic [2*c3s_pkg::DATA_W-1:0] mem_r [DEPTH];
  logic [2*c3s_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/conv3x3_stencil_stream_top.sv
`timescale 1ns / 1ps

// 3x3 convolution stencil over square padded tiles.
// in_*  : padded pixels, (side+2) x (side+2) per tile, raster order.
// out_* : one weighted window sum per pixel whose row and column are both at
//         least 2; out_tlast marks the last sum of a tile.
// cfg_* : register writes (tile side, coefficient pairs, last coefficient),
//         to be issued only while the block is idle; the block does not enforce it.
// Throughput: one pixel per cycle while the receiver does not stall. Each input
// transaction passes through the line buffer read, the window shift with
// the per-tap multipliers, the row sums, then the final add into the output
// register.
// The nine window taps form three chains of cells that shift once per pixel.
// A stalled receiver holds the output register; the three inner stages keep
// taking pixels until they fill up, then in_tready drops.
// Reset clears the tile position counters and pipeline valids, sets the tile
// side to 256 and all coefficients to zero. Line buffer contents stay
// undefined until a tile's first rows are written.
module conv3x3_stencil_stream_top #(
  parameter int MAX_TILE = c3s_pkg::MAX_TILE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: [31:0] pixel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [c3s_pkg::DATA_W-1:0]        in_tdata,
  // out_tdata: [31:0] result
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [c3s_pkg::DATA_W-1:0]        out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_wr_en,
  input  logic [c3s_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [c3s_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int DEPTH = MAX_TILE + 2;
  localparam int CW    = $clog2(DEPTH);
  localparam int SW    = (CW > c3s_pkg::TILE_SIDE_W) ? CW : c3s_pkg::TILE_SIDE_W;
  localparam int DW    = c3s_pkg::DATA_W;

  // configuration
  logic [c3s_pkg::TILE_SIDE_W-1:0] tile_side_r;
  c3s_pkg::word_t                  coeff_r [c3s_pkg::NUM_COEFF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_side_r <= c3s_pkg::TILE_SIDE_W'(c3s_pkg::TILE_SIDE_RST);
      for (int k = 0; k < c3s_pkg::NUM_COEFF; k++) begin
        coeff_r[k] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (c3s_pkg::cfg_reg_t'(cfg_index))
        c3s_pkg::REG_TILE_SIDE: begin
          tile_side_r <= cfg_wdata[c3s_pkg::TILE_SIDE_W-1:0];
        end
        c3s_pkg::REG_COEFF_PAIR_A: begin
          coeff_r[0] <= cfg_wdata[DW-1:0];
          coeff_r[1] <= cfg_wdata[2*DW-1:DW];
        end
        c3s_pkg::REG_COEFF_PAIR_B: begin
          coeff_r[2] <= cfg_wdata[DW-1:0];
          coeff_r[3] <= cfg_wdata[2*DW-1:DW];
        end
        c3s_pkg::REG_COEFF_PAIR_C: begin
          coeff_r[4] <= cfg_wdata[DW-1:0];
          coeff_r[5] <= cfg_wdata[2*DW-1:DW];
        end
        c3s_pkg::REG_COEFF_PAIR_D: begin
          coeff_r[6] <= cfg_wdata[DW-1:0];
          coeff_r[7] <= cfg_wdata[2*DW-1:DW];
        end
        c3s_pkg::REG_COEFF_LAST: begin
          coeff_r[8] <= cfg_wdata[DW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // last padded index = clamped side + 1
  logic [SW-1:0] side_w;
  logic [SW-1:0] eff_side;
  logic [SW-1:0] last_w;
  logic [CW-1:0] last;

  always_comb begin
    side_w = SW'(tile_side_r);
    if (side_w == '0) begin
      eff_side = SW'(1);
    end else if (side_w > SW'(MAX_TILE)) begin
      eff_side = SW'(MAX_TILE);
    end else begin
      eff_side = side_w;
    end
    last_w = eff_side + SW'(1);
    last   = last_w[CW-1:0];
  end

  // stage enables, back to front
  logic en_out, en3, en2, en1;
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;

  assign en_out    = !out_v_r || out_tready;
  assign en3       = !s3_v_r || en_out;
  assign en2       = !s2_v_r || en3;
  assign en1       = !s1_v_r || en2;
  assign in_tready = en1;

  logic accept;
  assign accept = in_tvalid && in_tready;

  // tile position
  logic [CW-1:0] col_r, row_r;
  logic          emit, at_end;

  assign emit   = (row_r >= CW'(2)) && (col_r >= CW'(2));
  assign at_end = (row_r >= last) && (col_r >= last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (col_r >= last) begin
        col_r <= '0;
        row_r <= (row_r >= last) ? '0 : row_r + CW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // stage 1: line buffer read in flight
  c3s_pkg::word_t s1_pix_r;
  logic [CW-1:0]  s1_col_r;
  logic           s1_emit_r, s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_pix_r  <= in_tdata;
      s1_col_r  <= col_r;
      s1_emit_r <= emit;
      s1_last_r <= at_end;
    end
  end

  logic [2*DW-1:0] rd_data;
  logic            shift;

  assign shift = en2 && s1_v_r;

  c3s_line_mem #(
    .DEPTH (DEPTH)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (en1),
    .rd_addr (col_r),
    .rd_data (rd_data),
    .wr_en   (shift),
    .wr_addr (s1_col_r),
    .wr_data ({s1_pix_r, rd_data[2*DW-1:DW]})
  );

  // stage 2: window cells, three rows of three
  c3s_pkg::word_t row_in [3];
  c3s_pkg::word_t tap    [3][3];
  c3s_pkg::word_t prod   [3][3];

  assign row_in[0] = rd_data[DW-1:0];
  assign row_in[1] = rd_data[2*DW-1:DW];
  assign row_in[2] = s1_pix_r;

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      c3s_cell u_cell (
        .clk      (clk),
        .shift    (shift),
        .tap_in   ((j == 2) ? row_in[i] : tap[i][(j == 2) ? j : j + 1]),
        .coeff    (coeff_r[3*i+j]),
        .tap_out  (tap[i][j]),
        .prod_out (prod[i][j])
      );
    end
  end

  logic s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_last_r <= s1_last_r;
    end
  end

  // stage 3: row sums
  c3s_pkg::word_t row_sum_r [3];
  logic           s3_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int i = 0; i < 3; i++) begin
        row_sum_r[i] <= prod[i][0] + prod[i][1] + prod[i][2];
      end
      s3_last_r <= s2_last_r;
    end
  end

  // output register
  c3s_pkg::word_t out_data_r;
  logic           out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en_out) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_data_r <= row_sum_r[0] + row_sum_r[1] + row_sum_r[2];
      out_last_r <= s3_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  ap_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= CW'(MAX_TILE + 1))
    else $error("column counter beyond padded line");

  ap_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_last_r |-> s1_emit_r)
    else $error("tile end on a pixel without output");

  ap_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (col_r >= last) |=> col_r == '0)
    else $error("column did not wrap at end of row");

  ap_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready && s3_v_r && s2_v_r && s1_v_r |-> !in_tready)
    else $error("input taken while pipeline full and stalled");

endmodule
